// ===== design/mcbf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbf_pkg
// Shared types and constants for the multi-channel byte FIFO core.
// ----------------------------------------------------------------------------
package mcbf_pkg;

    // Bank geometry.
    localparam int NUM_QUEUES  = 4;
    localparam int QUEUE_DEPTH = 16;

    // Field widths of the request and the result.
    localparam int KIND_W  = 2;
    localparam int QUEUE_W = 3;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 5;

    // Derived storage widths.
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(MEM_DEPTH);

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic issue;        // Request accepted: update queue state and memory.
        logic load_result;  // Capture the finished result into the output register.
    } dp_cmd_t;

endpackage

// ===== design/mcbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcbf_ctrl
// Controller: sequences each request through issue and result capture and
// owns the handshake on both stream channels.
// ----------------------------------------------------------------------------
module mcbf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mcbf_pkg::dp_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_ACCESS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register is free at the next edge if empty or being drained.
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        cmd.issue       = 1'b0;
        cmd.load_result = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && out_free)
                begin
                    cmd.issue  = 1'b1;
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                cmd.load_result = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/mcbf_datapath.sv =====
// ----------------------------------------------------------------------------
// mcbf_datapath
// Datapath: per-queue pointers and counts, the shared byte store, and the
// result register.
// ----------------------------------------------------------------------------
module mcbf_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  mcbf_pkg::dp_cmd_t                  cmd,
    input  logic [mcbf_pkg::KIND_W-1:0]        kind,
    input  logic [mcbf_pkg::QUEUE_W-1:0]       queue_id,
    input  logic [mcbf_pkg::BYTE_W-1:0]        write_byte,
    output logic [mcbf_pkg::STAT_W-1:0]        status,
    output logic [mcbf_pkg::BYTE_W-1:0]        read_byte,
    output logic [mcbf_pkg::FILL_W-1:0]        fill_count,
    output logic                               is_full
);

    localparam int PTR_W  = mcbf_pkg::PTR_W;
    localparam int CNT_W  = mcbf_pkg::CNT_W;
    localparam int QIDX_W = mcbf_pkg::QIDX_W;
    localparam int ADDR_W = mcbf_pkg::ADDR_W;
    localparam int BYTE_W = mcbf_pkg::BYTE_W;

    // Per-queue control state.
    logic [PTR_W-1:0] wr_ptr_reg [mcbf_pkg::NUM_QUEUES];
    logic [PTR_W-1:0] rd_ptr_reg [mcbf_pkg::NUM_QUEUES];
    logic [CNT_W-1:0] count_reg  [mcbf_pkg::NUM_QUEUES];

    // Shared byte store and its registered read port.
    logic [BYTE_W-1:0] mem [mcbf_pkg::MEM_DEPTH];
    logic [BYTE_W-1:0] mem_rdata_reg;

    // Pending result between issue and capture.
    mcbf_pkg::status_t pend_status_reg;
    mcbf_pkg::status_t pend_status_next;
    logic [CNT_W-1:0]  pend_count_reg;
    logic [CNT_W-1:0]  pend_count_next;
    logic              pend_hit_reg;
    logic              pend_hit_next;

    // Result register.
    logic [mcbf_pkg::STAT_W-1:0] status_reg;
    logic [BYTE_W-1:0]           read_byte_reg;
    logic [mcbf_pkg::FILL_W-1:0] fill_count_reg;
    logic                        is_full_reg;

    // Decode of the current request.
    logic              q_valid;
    logic [QIDX_W-1:0] qi;
    logic [PTR_W-1:0]  cur_wr;
    logic [PTR_W-1:0]  cur_rd;
    logic [CNT_W-1:0]  cur_cnt;
    logic [PTR_W-1:0]  nxt_wr;
    logic [PTR_W-1:0]  nxt_rd;
    logic              do_write;
    logic              do_read;
    logic              do_flush;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  cnt_full;

    assign cnt_full = CNT_W'(mcbf_pkg::QUEUE_DEPTH);
    assign q_valid  = (int'(queue_id) < mcbf_pkg::NUM_QUEUES);
    assign qi       = QIDX_W'(queue_id);
    assign cur_wr   = wr_ptr_reg[qi];
    assign cur_rd   = rd_ptr_reg[qi];
    assign cur_cnt  = count_reg[qi];

    // Circular pointer advance.
    assign nxt_wr = (cur_wr == PTR_W'(mcbf_pkg::QUEUE_DEPTH - 1)) ? '0 : cur_wr + 1'b1;
    assign nxt_rd = (cur_rd == PTR_W'(mcbf_pkg::QUEUE_DEPTH - 1)) ? '0 : cur_rd + 1'b1;

    // Store address: queue base plus slot.
    assign wr_addr = ADDR_W'(ADDR_W'(qi) * ADDR_W'(mcbf_pkg::QUEUE_DEPTH)) + ADDR_W'(cur_wr);
    assign rd_addr = ADDR_W'(ADDR_W'(qi) * ADDR_W'(mcbf_pkg::QUEUE_DEPTH)) + ADDR_W'(cur_rd);

    // Request decode, status and the count after the step.
    always_comb
    begin
        do_write         = 1'b0;
        do_read          = 1'b0;
        do_flush         = 1'b0;
        pend_status_next = mcbf_pkg::ST_OK;
        pend_count_next  = cur_cnt;
        pend_hit_next    = 1'b0;
        if (!q_valid)
        begin
            pend_status_next = mcbf_pkg::ST_INVALID;
            pend_count_next  = '0;
        end
        else
        begin
            case (mcbf_pkg::kind_t'(kind))
                mcbf_pkg::KIND_WRITE:
                begin
                    if (cur_cnt >= cnt_full)
                    begin
                        pend_status_next = mcbf_pkg::ST_FULL;
                    end
                    else
                    begin
                        do_write        = 1'b1;
                        pend_count_next = cur_cnt + 1'b1;
                    end
                end
                mcbf_pkg::KIND_READ:
                begin
                    if (cur_cnt == '0)
                    begin
                        pend_status_next = mcbf_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        do_read         = 1'b1;
                        pend_hit_next   = 1'b1;
                        pend_count_next = cur_cnt - 1'b1;
                    end
                end
                mcbf_pkg::KIND_FLUSH:
                begin
                    do_flush        = 1'b1;
                    pend_count_next = '0;
                end
                default:
                begin
                    pend_status_next = mcbf_pkg::ST_OK;
                end
            endcase
        end
    end

    // Per-queue pointer and count update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcbf_pkg::NUM_QUEUES; i++)
            begin
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end
        else if (cmd.issue && q_valid)
        begin
            if (do_write)
            begin
                wr_ptr_reg[qi] <= nxt_wr;
            end
            if (do_read)
            begin
                rd_ptr_reg[qi] <= nxt_rd;
            end
            if (do_flush)
            begin
                wr_ptr_reg[qi] <= '0;
                rd_ptr_reg[qi] <= '0;
            end
            count_reg[qi] <= pend_count_next;
        end
    end

    // Byte store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.issue && do_write)
        begin
            mem[wr_addr] <= write_byte;
        end
        if (cmd.issue)
        begin
            mem_rdata_reg <= mem[rd_addr];
        end
    end

    // Pending result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            pend_status_reg <= pend_status_next;
            pend_count_reg  <= pend_count_next;
            pend_hit_reg    <= pend_hit_next;
        end
    end

    // Result register, loaded once the store read has completed.
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            status_reg     <= pend_status_reg;
            read_byte_reg  <= pend_hit_reg ? mem_rdata_reg : '0;
            fill_count_reg <= mcbf_pkg::FILL_W'(pend_count_reg);
            is_full_reg    <= (pend_count_reg == cnt_full);
        end
    end

    assign status     = status_reg;
    assign read_byte  = read_byte_reg;
    assign fill_count = fill_count_reg;
    assign is_full    = is_full_reg;

endmodule

// ===== design/multi_channel_byte_fifo_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_byte_fifo_core
// Bank of independent circular byte queues behind one request stream.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_axis channel is one request: tuser carries the
//   kind (write, read, flush, query) and tdata the queue number and the byte
//   to write. Each request yields exactly one transfer on the m_axis channel:
//   tuser carries the status, tdata the byte read, the queue's fill count
//   and its full flag after the request.
//   A request passes two steps: at issue the pointers, counts and the byte
//   store are updated and the store is read; at capture the result is
//   captured in the output register. The registered read of the shared
//   byte store calls for the capture step, and no new request is taken
//   before the previous one has been captured, when its result is offered.
//   The output register parts the two sides: a new request is taken while
//   the previous result is still offered, as long as it is drained by then.
//   While the receiver stalls with a result held, no request is accepted.
//   Reset empties every queue at once; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
module multi_channel_byte_fifo_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: queue_id [2:0], write_byte [10:3], zero [15:11].
    input  logic [mcbf_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // tuser: kind [1:0].
    input  logic [mcbf_pkg::KIND_W-1:0]       s_axis_tuser,
    // Result channel.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: read_byte [7:0], fill_count [12:8], is_full [13], zero [15:14].
    output logic [mcbf_pkg::M_DATA_W-1:0]     m_axis_tdata,
    // tuser: status [1:0].
    output logic [mcbf_pkg::STAT_W-1:0]       m_axis_tuser
);

    mcbf_pkg::dp_cmd_t            cmd;
    logic [mcbf_pkg::BYTE_W-1:0]  read_byte;
    logic [mcbf_pkg::FILL_W-1:0]  fill_count;
    logic                         is_full;

    // Handshake and sequencing.
    mcbf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // Queue state, byte store and result register.
    mcbf_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (s_axis_tuser),
        .queue_id   (s_axis_tdata[2:0]),
        .write_byte (s_axis_tdata[10:3]),
        .status     (m_axis_tuser),
        .read_byte  (read_byte),
        .fill_count (fill_count),
        .is_full    (is_full)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {2'b00, is_full, fill_count, read_byte};

endmodule
